// ===== hw/rtl/b2bt_pkg.sv =====
// Package for the binary to balanced ternary converter.
// Holds widths, the divide-by-three reciprocal, digit codes and the step result type.
// No dependencies.
package b2bt_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int MAX_TRITS       = 21;
   localparam int MAG_WIDTH       = VALUE_WIDTH + 1;
   localparam int QUOT_WIDTH      = VALUE_WIDTH - 1;
   localparam int COUNT_WIDTH     = $clog2(MAX_TRITS + 1);
   localparam int INDEX_WIDTH     = $clog2(MAX_TRITS);
   localparam int TRIT_WIDTH      = 2;
   localparam int REQ_TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((TRIT_WIDTH + 7) / 8) * 8;

   // ceil(2^(W+1) / 3): exact floor(t / 3) as (t * RECIP) >> (W+1) for any W-bit t
   localparam logic [VALUE_WIDTH+1:0] RECIP_WIDE =
      (({{(VALUE_WIDTH+1){1'b0}}, 1'b1} << (VALUE_WIDTH + 1)) + (VALUE_WIDTH+2)'(2)) /
      (VALUE_WIDTH+2)'(3);
   localparam logic [VALUE_WIDTH-1:0] RECIP = RECIP_WIDE[VALUE_WIDTH-1:0];

   localparam logic [TRIT_WIDTH-1:0] TRIT_ZERO  = 2'b00;
   localparam logic [TRIT_WIDTH-1:0] TRIT_PLUS  = 2'b01;
   localparam logic [TRIT_WIDTH-1:0] TRIT_MINUS = 2'b11;

   typedef struct packed {
      logic [QUOT_WIDTH-1:0] quot;
      logic [1:0]            rem;
   } step_type;

endpackage

// ===== hw/rtl/binary_to_balanced_ternary.sv =====
// Top level: signed binary to balanced ternary, digits out most significant first.
// Depends on b2bt_pkg and b2bt_div3.
//
//   channel  dir  tdata fields (low bit up)   tuser  tlast
//   req_     in   number[31:0]                -      -
//   rsp_     out  trit[1:0], zero pad [7:2]   -      last digit
//
// An item of n digits (1..21) is accepted, then goes through the shared
// divide-by-three unit (one digit per cycle), then leaves as n output transfers.
// req_tready is high only while idle; the next item is taken while the final
// digit still sits in the output register.
// rsp_tready low holds the output register and pauses digit emission.
// Synchronous active-high reset clears the sequencer and the output valid.
module binary_to_balanced_ternary (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [b2bt_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,  // number[31:0]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [b2bt_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,  // trit[1:0], zero [7:2]
   output logic                                  rsp_tlast
);
   import b2bt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [MAG_WIDTH-1:0]   mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TRIT_WIDTH-1:0]  rsp_trit_ff, rsp_trit_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [TRIT_WIDTH-1:0]  store_ff [MAX_TRITS];

   logic [VALUE_WIDTH-1:0] dividend;
   step_type               step;
   logic [TRIT_WIDTH-1:0]  trit;
   logic [COUNT_WIDTH-1:0] count_plus;
   logic [COUNT_WIDTH-1:0] count_minus;
   logic                   slot_free;
   logic                   req_fire;

   assign dividend    = mag_ff[VALUE_WIDTH-1:0] + VALUE_WIDTH'(1);
   assign count_plus  = count_ff + COUNT_WIDTH'(1);
   assign count_minus = count_ff - COUNT_WIDTH'(1);
   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;

   b2bt_div3 u_div3 (
      .dividend (dividend),
      .result   (step)
   );

   // remainder of (m+1)/3, less one, is the digit; sign flips it
   always_comb begin
      unique case (step.rem)
         2'd0: begin
            trit = neg_ff ? TRIT_PLUS : TRIT_MINUS;
         end
         2'd1: begin
            trit = TRIT_ZERO;
         end
         2'd2: begin
            trit = neg_ff ? TRIT_MINUS : TRIT_PLUS;
         end
         default: begin
            trit = TRIT_ZERO;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_trit_in  = rsp_trit_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in   = req_tdata[VALUE_WIDTH-1];
               mag_in   = req_tdata[VALUE_WIDTH-1]
                        ? -{req_tdata[VALUE_WIDTH-1], req_tdata[VALUE_WIDTH-1:0]}
                        :  {1'b0, req_tdata[VALUE_WIDTH-1:0]};
               count_in = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            mag_in   = MAG_WIDTH'(step.quot);
            count_in = count_plus;
            if (step.quot == '0 || count_plus == COUNT_WIDTH'(MAX_TRITS)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_trit_in  = store_ff[count_minus[INDEX_WIDTH-1:0]];
               rsp_last_in  = (count_ff == COUNT_WIDTH'(1));
               count_in     = count_minus;
               if (count_ff == COUNT_WIDTH'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_trit_ff <= rsp_trit_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == ST_CONV) begin
         store_ff[count_ff[INDEX_WIDTH-1:0]] <= trit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'(rsp_trit_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/b2bt_div3.sv =====
// Divide-by-three unit: quotient by reciprocal multiply, remainder by back-multiply.
// Depends on b2bt_pkg.
module b2bt_div3 (
   input  logic [b2bt_pkg::VALUE_WIDTH-1:0] dividend,
   output b2bt_pkg::step_type               result
);
   import b2bt_pkg::*;

   logic [2*VALUE_WIDTH-1:0] product;
   logic [QUOT_WIDTH-1:0]    quot;
   logic [VALUE_WIDTH-1:0]   quot_ext;
   logic [VALUE_WIDTH-1:0]   diff;

   assign product  = (2*VALUE_WIDTH)'(dividend) * (2*VALUE_WIDTH)'(RECIP);
   assign quot     = product[2*VALUE_WIDTH-1:VALUE_WIDTH+1];
   assign quot_ext = VALUE_WIDTH'(quot);
   assign diff     = dividend - (quot_ext << 1) - quot_ext;

   assign result.quot = quot;
   assign result.rem  = diff[1:0];

endmodule
